/* hdl/cdglc_pkg.sv */
// ----------------------------------------------------------------------------
// cdglc_pkg: shared types and constants for the circuit depth checker
// Field widths, operation classes, verdict codes and register indexes.
// ----------------------------------------------------------------------------
package cdglc_pkg;

   localparam int OP_CLASS_W = 2;
   localparam int QUBIT_W    = 6;
   localparam int FIELD_W    = 16;
   localparam int LIMIT_W    = 17;
   localparam int VERDICT_W  = 2;
   localparam int CSR_IDX_W  = 2;

   localparam int QUBITS_DEFAULT     = 64;
   localparam int DEPTH_BITS_DEFAULT = 16;

   typedef enum logic [OP_CLASS_W-1:0] {
      OP_NONE = 2'd0,
      OP_ONE  = 2'd1,
      OP_TWO  = 2'd2
   } op_class_type;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_PASS      = 2'd0,
      VERDICT_TWO_QUBIT = 2'd1,
      VERDICT_TOTAL     = 2'd2,
      VERDICT_DEPTH     = 2'd3
   } verdict_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEPTH_LIMIT     = 2'd0,
      CSR_TWO_QUBIT_LIMIT = 2'd1,
      CSR_TOTAL_LIMIT     = 2'd2
   } csr_index_type;

endpackage

/* hdl/cdglc_if.sv */
// ----------------------------------------------------------------------------
// cdglc_if: gate request and result channels
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface cdglc_req_if import cdglc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [OP_CLASS_W-1:0] op_class;
   logic [QUBIT_W-1:0]    qubit_first;
   logic [QUBIT_W-1:0]    qubit_second;
   logic                  end_of_circuit;

   modport source (output valid, op_class, qubit_first, qubit_second, end_of_circuit,
                   input ready);
   modport sink   (input valid, op_class, qubit_first, qubit_second, end_of_circuit,
                   output ready);
endinterface

interface cdglc_rsp_if import cdglc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [FIELD_W-1:0]   op_depth;
   logic [FIELD_W-1:0]   peak_depth;
   logic [FIELD_W-1:0]   two_qubit_total;
   logic [FIELD_W-1:0]   gate_total;
   logic [VERDICT_W-1:0] verdict;
   logic                 verdict_valid;

   modport source (output valid, op_depth, peak_depth, two_qubit_total, gate_total,
                          verdict, verdict_valid,
                   input ready);
   modport sink   (input valid, op_depth, peak_depth, two_qubit_total, gate_total,
                         verdict, verdict_valid,
                   output ready);
endinterface

/* hdl/circuit_depth_and_gate_limit_check_core.sv */
// ----------------------------------------------------------------------------
// circuit_depth_and_gate_limit_check_core: ASAP depth and gate limit checker
// Per-qubit depth table, gate counters and end-of-circuit limit verdict.
// ----------------------------------------------------------------------------
// Takes one gate transaction per clock while the result side is not stalled
// and returns one result transaction per gate. The first stage reads both
// target depths from the depth table (two memory banks, one written per
// target, with a per-qubit bank select and valid bit); the second forms
// max(target depths)+1, writes it back and updates the counters. The item
// that ends a circuit carries the verdict and clears the table through the
// valid bits, so the next circuit may follow immediately. The user must write
// limit registers only while no transaction is in flight; nothing enforces it.
module circuit_depth_and_gate_limit_check_core
   import cdglc_pkg::*;
#(
   parameter int QUBITS     = QUBITS_DEFAULT,
   parameter int DEPTH_BITS = DEPTH_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   cdglc_req_if.sink            req_ch,
   cdglc_rsp_if.source          rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]   csr_wdata
);

   localparam int AW = $clog2(QUBITS);

   // stage 1 (after table read)
   logic                  s1_vld_ff;
   logic [OP_CLASS_W-1:0] s1_class_ff;
   logic [QUBIT_W-1:0]    s1_qa_ff;
   logic [QUBIT_W-1:0]    s1_qb_ff;
   logic                  s1_eoc_ff;

   // depth table banks and read data (bank, read address)
   logic [DEPTH_BITS-1:0] mem_a [QUBITS];
   logic [DEPTH_BITS-1:0] mem_b [QUBITS];
   logic [DEPTH_BITS-1:0] rd_aa_ff, rd_ab_ff, rd_ba_ff, rd_bb_ff;
   logic [QUBITS-1:0]     valid_ff;
   logic [QUBITS-1:0]     lvt_ff;

   // last committed write
   logic                  fwd_vld_ff;
   logic                  fwd_wa_ff, fwd_wb_ff;
   logic [AW-1:0]         fwd_ia_ff, fwd_ib_ff;
   logic [DEPTH_BITS-1:0] fwd_val_ff;

   // circuit state
   logic [DEPTH_BITS-1:0] max_ff;
   logic [FIELD_W-1:0]    two_cnt_ff, tot_cnt_ff;
   logic [LIMIT_W-1:0]    lim_depth_ff, lim_two_ff, lim_tot_ff;

   // result register
   logic                  rsp_vld_ff;
   logic [FIELD_W-1:0]    out_gdep_ff, out_cdep_ff, out_two_ff, out_tot_ff;
   logic [VERDICT_W-1:0]  out_verdict_ff;
   logic                  out_vv_ff;

   logic                  s1_go, req_fire;
   logic                  is_gate, is_two, in_a, in_b, hit_a, hit_b;
   logic [AW-1:0]         idx_a, idx_b, ridx_a, ridx_b;
   logic [DEPTH_BITS-1:0] dep_a, dep_b, dsel, gdep, max_in;
   logic [FIELD_W-1:0]    two_in, tot_in;
   logic                  wr_a, wr_b;
   logic                  ex_two, ex_tot, ex_dep;
   verdict_type           verdict_in;

   always_comb begin
      s1_go        = s1_vld_ff && (!rsp_vld_ff || rsp_ch.ready);
      req_ch.ready = !s1_vld_ff || s1_go;
      req_fire     = req_ch.valid && req_ch.ready;
      ridx_a       = AW'(req_ch.qubit_first);
      ridx_b       = AW'(req_ch.qubit_second);

      is_gate = (s1_class_ff == OP_ONE) || (s1_class_ff == OP_TWO);
      is_two  = (s1_class_ff == OP_TWO);
      in_a    = 32'(s1_qa_ff) < QUBITS;
      in_b    = 32'(s1_qb_ff) < QUBITS;
      idx_a   = AW'(s1_qa_ff);
      idx_b   = AW'(s1_qb_ff);
      hit_a   = fwd_vld_ff && ((fwd_wa_ff && fwd_ia_ff == idx_a) ||
                               (fwd_wb_ff && fwd_ib_ff == idx_a));
      hit_b   = fwd_vld_ff && ((fwd_wa_ff && fwd_ia_ff == idx_b) ||
                               (fwd_wb_ff && fwd_ib_ff == idx_b));

      if (!in_a)                dep_a = '0;
      else if (hit_a)           dep_a = fwd_val_ff;
      else if (!valid_ff[idx_a]) dep_a = '0;
      else                      dep_a = lvt_ff[idx_a] ? rd_ba_ff : rd_aa_ff;

      if (!in_b)                dep_b = '0;
      else if (hit_b)           dep_b = fwd_val_ff;
      else if (!valid_ff[idx_b]) dep_b = '0;
      else                      dep_b = lvt_ff[idx_b] ? rd_bb_ff : rd_ab_ff;

      dsel = (is_two && dep_b > dep_a) ? dep_b : dep_a;
      if (!is_gate)          gdep = '0;
      else if (dsel == '1)   gdep = dsel;
      else                   gdep = dsel + 1'b1;

      wr_a = s1_go && is_gate && in_a;
      wr_b = s1_go && is_two && in_b;

      max_in = (is_gate && gdep > max_ff) ? gdep : max_ff;
      two_in = (is_two && two_cnt_ff != '1) ? two_cnt_ff + 1'b1 : two_cnt_ff;
      tot_in = (is_gate && tot_cnt_ff != '1) ? tot_cnt_ff + 1'b1 : tot_cnt_ff;

      // -1 disables; any other negative limit always fails
      ex_two = (lim_two_ff != '1) &&
               (lim_two_ff[LIMIT_W-1] || two_in > lim_two_ff[FIELD_W-1:0]);
      ex_tot = (lim_tot_ff != '1) &&
               (lim_tot_ff[LIMIT_W-1] || tot_in > lim_tot_ff[FIELD_W-1:0]);
      ex_dep = (lim_depth_ff != '1) &&
               (lim_depth_ff[LIMIT_W-1] || 33'(max_in) > 33'(lim_depth_ff[FIELD_W-1:0]));

      priority if (!s1_eoc_ff) verdict_in = VERDICT_PASS;
      else if (ex_two)         verdict_in = VERDICT_TWO_QUBIT;
      else if (ex_tot)         verdict_in = VERDICT_TOTAL;
      else if (ex_dep)         verdict_in = VERDICT_DEPTH;
      else                     verdict_in = VERDICT_PASS;
   end

   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[idx_a] <= gdep;
      end
      if (wr_b) begin
         mem_b[idx_b] <= gdep;
      end
      if (req_fire) begin
         rd_aa_ff <= mem_a[ridx_a];
         rd_ab_ff <= mem_a[ridx_b];
         rd_ba_ff <= mem_b[ridx_a];
         rd_bb_ff <= mem_b[ridx_b];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_class_ff <= req_ch.op_class;
         s1_qa_ff    <= req_ch.qubit_first;
         s1_qb_ff    <= req_ch.qubit_second;
         s1_eoc_ff   <= req_ch.end_of_circuit;
      end
      if (s1_go) begin
         out_gdep_ff    <= FIELD_W'(gdep);
         out_cdep_ff    <= FIELD_W'(max_in);
         out_two_ff     <= two_in;
         out_tot_ff     <= tot_in;
         out_verdict_ff <= verdict_in;
         out_vv_ff      <= s1_eoc_ff;
         if (is_gate) begin
            fwd_wa_ff  <= in_a;
            fwd_wb_ff  <= is_two && in_b;
            fwd_ia_ff  <= idx_a;
            fwd_ib_ff  <= idx_b;
            fwd_val_ff <= gdep;
         end
         if (wr_a && !(wr_b && idx_b == idx_a)) begin
            lvt_ff[idx_a] <= 1'b0;
         end
         if (wr_b) begin
            lvt_ff[idx_b] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         rsp_vld_ff   <= 1'b0;
         fwd_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         max_ff       <= '0;
         two_cnt_ff   <= '0;
         tot_cnt_ff   <= '0;
         lim_depth_ff <= '1;
         lim_two_ff   <= '1;
         lim_tot_ff   <= '1;
      end else begin
         if (req_fire) begin
            s1_vld_ff <= 1'b1;
         end else if (s1_go) begin
            s1_vld_ff <= 1'b0;
         end

         if (s1_go) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_vld_ff <= 1'b0;
         end

         if (s1_go) begin
            if (s1_eoc_ff) begin
               fwd_vld_ff <= 1'b0;
               valid_ff   <= '0;
               max_ff     <= '0;
               two_cnt_ff <= '0;
               tot_cnt_ff <= '0;
            end else begin
               if (is_gate) begin
                  fwd_vld_ff <= 1'b1;
               end
               if (wr_a) begin
                  valid_ff[idx_a] <= 1'b1;
               end
               if (wr_b && !(wr_a && idx_a == idx_b)) begin
                  valid_ff[idx_b] <= 1'b1;
               end
               max_ff     <= max_in;
               two_cnt_ff <= two_in;
               tot_cnt_ff <= tot_in;
            end
         end

         if (csr_we) begin
            unique case (csr_index)
               CSR_DEPTH_LIMIT:     lim_depth_ff <= csr_wdata;
               CSR_TWO_QUBIT_LIMIT: lim_two_ff   <= csr_wdata;
               CSR_TOTAL_LIMIT:     lim_tot_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign rsp_ch.valid           = rsp_vld_ff;
   assign rsp_ch.op_depth        = out_gdep_ff;
   assign rsp_ch.peak_depth      = out_cdep_ff;
   assign rsp_ch.two_qubit_total = out_two_ff;
   assign rsp_ch.gate_total      = out_tot_ff;
   assign rsp_ch.verdict         = out_verdict_ff;
   assign rsp_ch.verdict_valid   = out_vv_ff;

endmodule

/* bench/tb_circuit_depth_and_gate_limit_check_core.sv */
// ----------------------------------------------------------------------------
// tb_circuit_depth_and_gate_limit_check_core: self-checking gate stream bench
// Drives decomposed gate transactions through randomly stalled valid/ready
// channels. A local depth table and set of counters predict each result, and
// every returned transaction is checked field by field in order. The run
// covers directed corner circuits and randomized circuits under varied limit
// settings.
// ----------------------------------------------------------------------------
module tb_circuit_depth_and_gate_limit_check_core import cdglc_pkg::*; ();

   localparam int                    QUBITS    = QUBITS_DEFAULT;
   localparam logic [OP_CLASS_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [FIELD_W-1:0]    FIELD_MAX = {FIELD_W{1'b1}};
   localparam logic [LIMIT_W-1:0]    LIMIT_OFF = {LIMIT_W{1'b1}};
   localparam logic [LIMIT_W-1:0]    LIMIT_MIN = {1'b1, {(LIMIT_W-1){1'b0}}};
   localparam logic [LIMIT_W-1:0]    LIMIT_M2  = {{(LIMIT_W-1){1'b1}}, 1'b0};

   typedef struct packed {
      logic [OP_CLASS_W-1:0] op_class;
      logic [QUBIT_W-1:0]    qubit_first;
      logic [QUBIT_W-1:0]    qubit_second;
      logic                  end_of_circuit;
   } gate_item_type;

   typedef struct packed {
      logic [FIELD_W-1:0]   op_depth;
      logic [FIELD_W-1:0]   peak_depth;
      logic [FIELD_W-1:0]   two_qubit_total;
      logic [FIELD_W-1:0]   gate_total;
      logic [VERDICT_W-1:0] verdict;
      logic                 verdict_valid;
   } gate_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [LIMIT_W-1:0]   csr_wdata;

   cdglc_req_if req_bus ();
   cdglc_rsp_if rsp_bus ();

   circuit_depth_and_gate_limit_check_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   gate_item_type   pending_gates[$];
   gate_result_type expected_results[$];
   gate_item_type   driven_gate;

   logic [FIELD_W-1:0] depth_table [QUBITS] = '{default: '0};
   logic [FIELD_W-1:0] model_peak      = '0;
   logic [FIELD_W-1:0] model_two_cnt   = '0;
   logic [FIELD_W-1:0] gate_count      = '0;
   logic [LIMIT_W-1:0] depth_limit     = LIMIT_OFF;
   logic [LIMIT_W-1:0] two_qubit_limit = LIMIT_OFF;
   logic [LIMIT_W-1:0] total_limit     = LIMIT_OFF;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int failures      = 0;

   function automatic bit over_limit(logic [FIELD_W-1:0] count, logic [LIMIT_W-1:0] limit);
      int lim;
      int cnt;
      lim = int'($signed(limit));
      cnt = int'(count);
      if (lim == -1)
         return 1'b0;
      return cnt > lim;
   endfunction

   function automatic gate_result_type predict_gate(gate_item_type g);
      gate_result_type r;
      logic [FIELD_W-1:0] d;
      logic [FIELD_W-1:0] gd;
      gd = '0;
      if (g.op_class == OP_ONE || g.op_class == OP_TWO) begin
         d = depth_table[g.qubit_first];
         if (g.op_class == OP_TWO && depth_table[g.qubit_second] > d)
            d = depth_table[g.qubit_second];
         gd = (d == FIELD_MAX) ? FIELD_MAX : d + 1'b1;
         depth_table[g.qubit_first] = gd;
         if (g.op_class == OP_TWO)
            depth_table[g.qubit_second] = gd;
         if (gd > model_peak)
            model_peak = gd;
         if (gate_count != FIELD_MAX)
            gate_count++;
         if (g.op_class == OP_TWO && model_two_cnt != FIELD_MAX)
            model_two_cnt++;
      end
      r.op_depth        = gd;
      r.peak_depth      = model_peak;
      r.two_qubit_total = model_two_cnt;
      r.gate_total      = gate_count;
      r.verdict         = VERDICT_PASS;
      r.verdict_valid   = g.end_of_circuit;
      if (g.end_of_circuit) begin
         if (over_limit(model_two_cnt, two_qubit_limit))
            r.verdict = VERDICT_TWO_QUBIT;
         else if (over_limit(gate_count, total_limit))
            r.verdict = VERDICT_TOTAL;
         else if (over_limit(model_peak, depth_limit))
            r.verdict = VERDICT_DEPTH;
         depth_table   = '{default: '0};
         model_peak    = '0;
         model_two_cnt = '0;
         gate_count    = '0;
      end
      return r;
   endfunction

   task automatic report_failure(string msg);
      failures++;
      if (failures <= 10)
         $display("%s", msg);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            expected_results.push_back(predict_gate(driven_gate));
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_gates.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               driven_gate = pending_gates.pop_front();
               req_bus.valid          <= 1'b1;
               req_bus.op_class       <= driven_gate.op_class;
               req_bus.qubit_first    <= driven_gate.qubit_first;
               req_bus.qubit_second   <= driven_gate.qubit_second;
               req_bus.end_of_circuit <= driven_gate.end_of_circuit;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : result_monitor
      gate_result_type seen;
      gate_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.op_depth        = rsp_bus.op_depth;
            seen.peak_depth      = rsp_bus.peak_depth;
            seen.two_qubit_total = rsp_bus.two_qubit_total;
            seen.gate_total      = rsp_bus.gate_total;
            seen.verdict         = rsp_bus.verdict;
            seen.verdict_valid   = rsp_bus.verdict_valid;
            if (expected_results.size() == 0) begin
               report_failure($sformatf("unexpected result transaction: %p", seen));
            end else begin
               want = expected_results.pop_front();
               if (seen.op_depth !== want.op_depth
                   || seen.peak_depth !== want.peak_depth
                   || seen.two_qubit_total !== want.two_qubit_total
                   || seen.gate_total !== want.gate_total
                   || seen.verdict !== want.verdict
                   || seen.verdict_valid !== want.verdict_valid)
                  report_failure($sformatf("result mismatch: expected %p, actual %p",
                                           want, seen));
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic void add_gate(logic [OP_CLASS_W-1:0] cls, logic [QUBIT_W-1:0] qa,
                                    logic [QUBIT_W-1:0] qb, logic last);
      gate_item_type g;
      g.op_class       = cls;
      g.qubit_first    = qa;
      g.qubit_second   = qb;
      g.end_of_circuit = last;
      pending_gates.push_back(g);
   endfunction

   function automatic void add_random_circuit(int length, int span);
      int pick;
      logic [OP_CLASS_W-1:0] cls;
      for (int i = 0; i < length; i++) begin
         pick = $urandom_range(99);
         if (pick < 8)
            cls = OP_NONE;
         else if (pick < 12)
            cls = OP_UNUSED;
         else if (pick < 52)
            cls = OP_ONE;
         else
            cls = OP_TWO;
         add_gate(cls, QUBIT_W'($urandom_range(span)), QUBIT_W'($urandom_range(span)),
                  i == length - 1);
      end
   endfunction

   function automatic logic [LIMIT_W-1:0] rand_limit();
      case ($urandom_range(9))
         0, 1:    return LIMIT_OFF;
         2:       return LIMIT_MIN | LIMIT_W'($urandom_range(65534));
         3:       return {1'b0, FIELD_MAX};
         4:       return LIMIT_W'($urandom_range(65535));
         default: return LIMIT_W'($urandom_range(30));
      endcase
   endfunction

   task automatic apply_limits(logic [LIMIT_W-1:0] depth, logic [LIMIT_W-1:0] two,
                               logic [LIMIT_W-1:0] total);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_DEPTH_LIMIT;
      csr_wdata <= depth;
      @(posedge clock);
      csr_index <= CSR_TWO_QUBIT_LIMIT;
      csr_wdata <= two;
      @(posedge clock);
      csr_index <= CSR_TOTAL_LIMIT;
      csr_wdata <= total;
      @(posedge clock);
      csr_we <= 1'b0;
      depth_limit     = depth;
      two_qubit_limit = two;
      total_limit     = total;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_gates.size() != 0 || req_bus.valid || expected_results.size() != 0);
   endtask

   initial begin
      int queued;
      int length;
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_index              = CSR_DEPTH_LIMIT;
      csr_wdata              = '0;
      req_bus.valid          = 1'b0;
      req_bus.op_class       = OP_NONE;
      req_bus.qubit_first    = '0;
      req_bus.qubit_second   = '0;
      req_bus.end_of_circuit = 1'b0;
      rsp_bus.ready          = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 23;
      recv_idle_pct = 48;

      // all limits disabled after reset
      add_gate(OP_NONE, 0, 0, 1'b0);
      add_gate(OP_ONE, 0, 0, 1'b0);
      add_gate(OP_ONE, 63, 0, 1'b0);
      add_gate(OP_TWO, 0, 63, 1'b0);
      add_gate(OP_TWO, 42, 42, 1'b0);
      add_gate(OP_TWO, 42, 42, 1'b0);
      add_gate(OP_UNUSED, 63, 0, 1'b0);
      add_gate(OP_TWO, 21, 42, 1'b0);
      add_gate(OP_ONE, 63, 21, 1'b1);
      add_gate(OP_NONE, 63, 63, 1'b1);
      add_gate(OP_ONE, 0, 0, 1'b1);
      wait_idle();

      // one circuit per verdict, plus priority of two-qubit over total
      apply_limits(17'd2, 17'd1, 17'd3);
      add_gate(OP_TWO, 0, 1, 1'b0);
      add_gate(OP_TWO, 2, 3, 1'b0);
      add_gate(OP_ONE, 4, 0, 1'b0);
      add_gate(OP_ONE, 5, 0, 1'b1);
      add_gate(OP_ONE, 0, 0, 1'b0);
      add_gate(OP_ONE, 1, 0, 1'b0);
      add_gate(OP_ONE, 2, 0, 1'b0);
      add_gate(OP_ONE, 3, 0, 1'b1);
      add_gate(OP_ONE, 5, 0, 1'b0);
      add_gate(OP_ONE, 5, 0, 1'b0);
      add_gate(OP_ONE, 5, 0, 1'b1);
      add_gate(OP_ONE, 5, 0, 1'b1);
      wait_idle();

      // negative limits other than -1 always fail
      apply_limits(LIMIT_M2, {1'b0, FIELD_MAX}, LIMIT_MIN);
      add_gate(OP_NONE, 0, 0, 1'b1);
      wait_idle();
      apply_limits(LIMIT_MIN, LIMIT_OFF, 17'd0);
      add_gate(OP_NONE, 0, 0, 1'b1);
      add_gate(OP_ONE, 7, 0, 1'b1);
      wait_idle();

      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 23 : (mode == 1) ? 48 : 0;
         recv_idle_pct = (mode == 0) ? 48 : (mode == 1) ? 23 : 0;
         for (int cfg = 0; cfg < 4; cfg++) begin
            apply_limits(rand_limit(), rand_limit(), rand_limit());
            queued = 0;
            while (queued < 115) begin
               length = ($urandom_range(9) == 0) ? $urandom_range(25, 80)
                                                 : $urandom_range(1, 16);
               add_random_circuit(length, ($urandom_range(2) == 0) ? 63
                                                                   : $urandom_range(1, 7));
               queued += length;
            end
            wait_idle();
         end
      end

      apply_limits(rand_limit(), rand_limit(), rand_limit());
      add_random_circuit(20, 7);
      add_random_circuit(12, 63);
      wait_idle();

      repeat (4) @(posedge clock);
      if (failures == 0)
         $display("circuit_depth_and_gate_limit_check_core regression: pass");
      else
         $display("circuit_depth_and_gate_limit_check_core regression: fail");
      $finish;
   end

   initial begin
      #20000000;
      $display("circuit_depth_and_gate_limit_check_core regression: fail");
      $finish;
   end

endmodule

/* filelist.f */
hdl/cdglc_pkg.sv
hdl/cdglc_if.sv
hdl/circuit_depth_and_gate_limit_check_core.sv
bench/tb_circuit_depth_and_gate_limit_check_core.sv
